FILE: hdl/tmmh_pkg.sv
// ----------------------------------------------------------------------------
// tmmh_pkg
// shared types, constants and helpers for the timer multiplexer
// ----------------------------------------------------------------------------
package tmmh_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic       OP_ARM    = 1'b0;
    localparam logic       OP_EXPIRE = 1'b1;

    localparam logic [2:0] KIND_FIRE     = 3'd0;
    localparam logic [2:0] KIND_PROGRAM  = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [31:0] timeout;
        logic [7:0]  callback_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  fired_handle;
        logic [31:0] delay_ms;
        logic        last;
    } rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_arm;
        logic [31:0] timeout;
        logic [7:0]  handle;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_ARM_SCAN,
        ST_ARM_DONE,
        ST_EXP_START,
        ST_EXP_SCAN,
        ST_EXP_DECIDE,
        ST_FIRE
    } back_state_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    // delay from now to an expiry, clamped at zero and saturated at 32 bits
    function automatic logic [31:0] delay_to(input logic [47:0] expiry,
                                             input logic [47:0] now);
        logic [47:0] d;
        d = expiry - now;
        if (expiry <= now)
            return 32'd0;
        if (|d[47:32])
            return 32'hFFFF_FFFF;
        return d[31:0];
    endfunction

endpackage

FILE: hdl/tmmh_front.sv
// ----------------------------------------------------------------------------
// tmmh_front
// takes requests, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module tmmh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tmmh_pkg::req_t req,
    output logic           cmd_valid,
    output tmmh_pkg::cmd_t cmd,
    input  logic           cmd_pop
);
    import tmmh_pkg::*;

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;
    cmd_t              cls;

    assign req_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push      = req_valid && req_ready;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        cls.is_arm  = (req.operation == OP_ARM);
        cls.timeout = req.timeout;
        cls.handle  = req.callback_handle;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

endmodule

FILE: hdl/tmmh_back.sv
// ----------------------------------------------------------------------------
// tmmh_back
// timer store, earliest-entry scan sequencer and result register
// ----------------------------------------------------------------------------
module tmmh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tmmh_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tmmh_pkg::rsp_t rsp
);
    import tmmh_pkg::*;

    logic [47:0] exp_mem  [SLOTS];
    logic [7:0]  hand_mem [SLOTS];
    logic [15:0] arr_mem  [SLOTS];

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [15:0] arrival_reg, arrival_next;
    logic [47:0] now_reg, now_next;
    logic [31:0] pd_reg, pd_next;
    logic [47:0] new_exp_reg, new_exp_next;
    logic [7:0]  new_hand_reg, new_hand_next;
    logic        early_reg, early_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [47:0] best_exp_reg, best_exp_next;
    logic [15:0] best_arr_reg, best_arr_next;
    logic [7:0]  best_hand_reg, best_hand_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    logic [IDX_W-1:0] rd_idx;
    logic [47:0] rd_exp;
    logic [15:0] rd_arr;
    logic [7:0]  rd_hand;
    logic [15:0] arr_diff;
    logic        rd_before;
    logic        can_emit;
    logic [CNT_W-1:0] last_cnt;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [47:0]      wr_exp;
    logic [7:0]       wr_hand;
    logic [15:0]      wr_arr;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign can_emit  = !rsp_valid_reg || rsp_ready;
    assign last_cnt  = count_reg - 1'b1;

    // single shared read port into the store
    always_comb
    begin
        unique case (state_reg)
            ST_ARM_SCAN,
            ST_EXP_SCAN:   rd_idx = scan_reg[IDX_W-1:0];
            ST_EXP_DECIDE: rd_idx = last_cnt[IDX_W-1:0];
            default:       rd_idx = '0;
        endcase
    end

    assign rd_exp    = exp_mem[rd_idx];
    assign rd_arr    = arr_mem[rd_idx];
    assign rd_hand   = hand_mem[rd_idx];
    assign arr_diff  = rd_arr - best_arr_reg;
    assign rd_before = (rd_exp < best_exp_reg) ||
                       ((rd_exp == best_exp_reg) && arr_diff[15]);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        arrival_next   = arrival_reg;
        now_next       = now_reg;
        pd_next        = pd_reg;
        new_exp_next   = new_exp_reg;
        new_hand_next  = new_hand_reg;
        early_next     = early_reg;
        best_idx_next  = best_idx_reg;
        best_exp_next  = best_exp_reg;
        best_arr_next  = best_arr_reg;
        best_hand_next = best_hand_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_exp         = new_exp_reg;
        wr_hand        = new_hand_reg;
        wr_arr         = arrival_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_arm)
                    begin
                        new_exp_next  = sat_add48(now_reg, {16'd0, cmd.timeout});
                        new_hand_next = cmd.handle;
                        early_next    = 1'b1;
                        scan_next     = '0;
                        if (count_reg == CNT_W'(SLOTS))
                            state_next = ST_REJECT;
                        else
                            state_next = ST_ARM_SCAN;
                    end
                    else
                    begin
                        now_next   = sat_add48(now_reg, {16'd0, pd_reg});
                        state_next = ST_EXP_START;
                    end
                end
            end

            ST_REJECT:
            begin
                if (can_emit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{KIND_REJECTED, 8'd0, 32'd0, 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            ST_ARM_SCAN:
            begin
                if (scan_reg == count_reg)
                    state_next = ST_ARM_DONE;
                else
                begin
                    if (rd_exp < new_exp_reg)
                        early_next = 1'b0;
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_ARM_DONE:
            begin
                if (can_emit)
                begin
                    wr_en          = 1'b1;
                    wr_idx         = count_reg[IDX_W-1:0];
                    count_next     = count_reg + 1'b1;
                    arrival_next   = arrival_reg + 1'b1;
                    rsp_valid_next = 1'b1;
                    if (early_reg)
                    begin
                        pd_next  = delay_to(new_exp_reg, now_reg);
                        rsp_next = '{KIND_PROGRAM, 8'd0, delay_to(new_exp_reg, now_reg), 1'b1};
                    end
                    else
                        rsp_next = '{KIND_ACCEPTED, 8'd0, 32'd0, 1'b1};
                    state_next = ST_IDLE;
                end
            end

            ST_EXP_START:
            begin
                if (count_reg == '0)
                begin
                    if (can_emit)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{KIND_IDLE, 8'd0, 32'd0, 1'b1};
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    best_idx_next  = '0;
                    best_exp_next  = rd_exp;
                    best_arr_next  = rd_arr;
                    best_hand_next = rd_hand;
                    scan_next      = CNT_W'(1);
                    state_next     = ST_EXP_SCAN;
                end
            end

            ST_EXP_SCAN:
            begin
                if (scan_reg == count_reg)
                    state_next = ST_EXP_DECIDE;
                else
                begin
                    if (rd_before)
                    begin
                        best_idx_next  = scan_reg[IDX_W-1:0];
                        best_exp_next  = rd_exp;
                        best_arr_next  = rd_arr;
                        best_hand_next = rd_hand;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_EXP_DECIDE:
            begin
                if (best_exp_reg > now_reg)
                begin
                    if (can_emit)
                    begin
                        pd_next        = delay_to(best_exp_reg, now_reg);
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{KIND_PROGRAM, 8'd0,
                                           delay_to(best_exp_reg, now_reg), 1'b1};
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // move the last live entry into the freed slot
                    wr_en      = 1'b1;
                    wr_idx     = best_idx_reg;
                    wr_exp     = rd_exp;
                    wr_hand    = rd_hand;
                    wr_arr     = rd_arr;
                    count_next = last_cnt;
                    state_next = (best_hand_reg != 8'd0) ? ST_FIRE : ST_EXP_START;
                end
            end

            ST_FIRE:
            begin
                if (can_emit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{KIND_FIRE, best_hand_reg, 32'd0, 1'b0};
                    state_next     = ST_EXP_START;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            arrival_reg   <= '0;
            now_reg       <= '0;
            pd_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            arrival_reg   <= arrival_next;
            now_reg       <= now_next;
            pd_reg        <= pd_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        new_exp_reg   <= new_exp_next;
        new_hand_reg  <= new_hand_next;
        early_reg     <= early_next;
        best_idx_reg  <= best_idx_next;
        best_exp_reg  <= best_exp_next;
        best_arr_reg  <= best_arr_next;
        best_hand_reg <= best_hand_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            exp_mem[wr_idx]  <= wr_exp;
            hand_mem[wr_idx] <= wr_hand;
            arr_mem[wr_idx]  <= wr_arr;
        end
    end

endmodule

FILE: hdl/timer_multiplexer_min_heap_core.sv
// ----------------------------------------------------------------------------
// timer_multiplexer_min_heap_core
// many logical one-shot timers sharing one hardware one-shot timer
// ----------------------------------------------------------------------------
// req channel: arm (timeout, callback_handle) or expiry requests, valid/ready
// rsp channel: kind, fired_handle, delay_ms, last; last marks the final
//   response of a request, an expiry request may give several fire responses
// a two-entry request queue lets requests be taken while the sequencer works
// an arm does a linear scan of the live timers in the store, a rejected arm
//   does none; an expiry advances the clock, then per removed timer scans the
//   store and emits a fire (none for handle zero), then rescans to program the
//   next delay or answers idle when the store is empty; all scans go through
//   the single-port store in the sequencer
// a response is held in the output register until rsp_ready; while it is
//   held the sequencer waits once it has a next response to give, but the request queue keeps filling
// reset empties the queue and the store, zeroes the software clock, the
//   arrival counter and the programmed delay
// ----------------------------------------------------------------------------
module timer_multiplexer_min_heap_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tmmh_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tmmh_pkg::rsp_t rsp
);
    import tmmh_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    tmmh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tmmh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: sim/timer_multiplexer_min_heap_core_test.sv
// ----------------------------------------------------------------------------
// timer_multiplexer_min_heap_core_test
// drives arm and expiry requests with random gaps and stalls, predicts every
// response from a software copy of the timer store and checks them in order
// ----------------------------------------------------------------------------
class timer_scoreboard;

    logic [47:0] expiry_at [$];
    logic [7:0]  handle_of [$];
    logic [15:0] stamp_of  [$];
    logic [15:0] next_stamp;
    logic [47:0] now_ms;
    logic [31:0] loaded_delay;
    tmmh_pkg::rsp_t pending [$];
    int errors;

    function void clear();
        expiry_at = {};
        handle_of = {};
        stamp_of = {};
        next_stamp = '0;
        now_ms = '0;
        loaded_delay = '0;
        pending = {};
        errors = 0;
    endfunction

    function logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function logic [31:0] delay_from_now(logic [47:0] e);
        logic [47:0] d;
        d = e - now_ms;
        if (e <= now_ms)
            return '0;
        return (|d[47:32]) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    function int earliest();
        int best;
        logic [15:0] diff;
        best = 0;
        for (int i = 1; i < expiry_at.size(); i++)
        begin
            diff = stamp_of[i] - stamp_of[best];
            if (expiry_at[i] < expiry_at[best] ||
                (expiry_at[i] == expiry_at[best] && diff[15]))
                best = i;
        end
        return best;
    endfunction

    function void push(logic [2:0] k, logic [7:0] h, logic [31:0] d, logic l);
        tmmh_pkg::rsp_t r;
        r.kind = k;
        r.fired_handle = h;
        r.delay_ms = d;
        r.last = l;
        pending.push_back(r);
    endfunction

    function void note_request(tmmh_pkg::req_t q);
        logic [47:0] e;
        bit first;
        int s, n;
        if (q.operation == tmmh_pkg::OP_ARM)
        begin
            if (expiry_at.size() >= tmmh_pkg::SLOTS)
            begin
                push(tmmh_pkg::KIND_REJECTED, 0, 0, 1);
                return;
            end
            e = add_sat(now_ms, {16'd0, q.timeout});
            first = 1;
            foreach (expiry_at[i])
                if (expiry_at[i] < e)
                    first = 0;
            expiry_at.push_back(e);
            handle_of.push_back(q.callback_handle);
            stamp_of.push_back(next_stamp);
            next_stamp++;
            if (first)
            begin
                loaded_delay = delay_from_now(e);
                push(tmmh_pkg::KIND_PROGRAM, 0, loaded_delay, 1);
            end
            else
                push(tmmh_pkg::KIND_ACCEPTED, 0, 0, 1);
            return;
        end
        now_ms = add_sat(now_ms, {16'd0, loaded_delay});
        while (expiry_at.size() > 0)
        begin
            s = earliest();
            if (expiry_at[s] > now_ms)
                break;
            if (handle_of[s] != 0)
                push(tmmh_pkg::KIND_FIRE, handle_of[s], 0, 0);
            // removal moves the last entry into the hole, as the store does
            n = expiry_at.size() - 1;
            expiry_at[s] = expiry_at[n];
            handle_of[s] = handle_of[n];
            stamp_of[s] = stamp_of[n];
            expiry_at.delete(n);
            handle_of.delete(n);
            stamp_of.delete(n);
        end
        if (expiry_at.size() > 0)
        begin
            loaded_delay = delay_from_now(expiry_at[earliest()]);
            push(tmmh_pkg::KIND_PROGRAM, 0, loaded_delay, 1);
        end
        else
            push(tmmh_pkg::KIND_IDLE, 0, 0, 1);
    endfunction

    function void check_response(tmmh_pkg::rsp_t r);
        tmmh_pkg::rsp_t x;
        if (pending.size() == 0)
        begin
            $error("unexpected response kind %0d", r.kind);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (r.kind !== x.kind)
        begin
            $error("kind: expected %0d, got %0d", x.kind, r.kind);
            errors++;
        end
        if (r.fired_handle !== x.fired_handle)
        begin
            $error("fired_handle: expected %0d, got %0d", x.fired_handle, r.fired_handle);
            errors++;
        end
        if (r.delay_ms !== x.delay_ms)
        begin
            $error("delay_ms: expected %0d, got %0d", x.delay_ms, r.delay_ms);
            errors++;
        end
        if (r.last !== x.last)
        begin
            $error("last: expected %0d, got %0d", x.last, r.last);
            errors++;
        end
    endfunction

endclass

module timer_multiplexer_min_heap_core_test;

    import tmmh_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 0;
    rsp_t rsp;

    timer_scoreboard timers;
    bit sending_done = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    timer_multiplexer_min_heap_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #1 clk = ~clk;

    function int gap_length();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // valid stays high between back-to-back requests, dropped only for a gap or a drain
    task automatic send_request(logic op, logic [31:0] t, logic [7:0] h);
        int g;
        req_t r;
        g = gap_length();
        if (g > 0)
        begin
            req_valid <= 0;
            repeat (g) @(negedge clk);
        end
        r.operation = op;
        r.timeout = t;
        r.callback_handle = h;
        req <= r;
        req_valid <= 1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        timers.note_request(req);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 0;
        while (timers.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function logic [31:0] random_timeout();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom;
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    task automatic run_stimulus();
        int arms;
        // directed: extremes, ties, handle zero, spurious expiry, full store
        send_request(OP_EXPIRE, 0, 0);
        send_request(OP_ARM, 32'hFFFF_FFFF, 8'hFF);
        send_request(OP_ARM, 0, 8'h00);
        send_request(OP_ARM, 0, 8'h01);
        send_request(OP_ARM, 5, 8'hAA);
        send_request(OP_ARM, 5, 8'h55);
        send_request(OP_EXPIRE, 0, 0);
        send_request(OP_EXPIRE, 0, 0);
        for (int i = 0; i < 14; i++)
            send_request(OP_ARM, 32'hFFFF_FFF0 + i, i[7:0]);
        send_request(OP_ARM, 7, 8'h77);
        send_request(OP_EXPIRE, 32'hFFFF_FFFF, 8'hFF);
        wait_drained();
        // random: arms and expiries mixed at random, with a drain halfway through
        arms = 0;
        while (arms < 340)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                send_request(OP_EXPIRE, $urandom, 8'($urandom));
            end
            else
            begin
                send_request(OP_ARM, random_timeout(),
                             $urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom));
            end
            arms++;
            if (arms == 170)
                wait_drained();
        end
    endtask

    initial
    begin
        timers = new();
        timers.clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        run_stimulus();
        wait_drained();
        sending_done = 1;
    end

    // receiver stalls at random, mostly short, now and then a long one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) == 0)
        begin
            rsp_ready <= 0;
            stall_left <= $urandom_range(10, 40);
        end
        else if ($urandom_range(0, 9) < 6)
            rsp_ready <= 1;
        else
            rsp_ready <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            timers.check_response(rsp);
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (sending_done || quiet_cycles >= STALL_LIMIT);
        if (sending_done && timers.errors == 0 && timers.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
